FILE: design/address_range_table_macros.svh
// ----------------------------------------------------------------------------
// Address range table assertion macros
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_TABLE_MACROS_SVH
`define ADDRESS_RANGE_TABLE_MACROS_SVH

// same-cycle implication
`define ART_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ART_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/art_pkg.sv
// ----------------------------------------------------------------------------
// Address range table package
// Field widths, item kinds and sequencer states.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int unsigned AddrW = 48;
  localparam int unsigned KindW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_DROP
  } state_e;

  typedef logic [AddrW-1:0] addr_t;

endpackage

FILE: design/address_range_table.sv
// ----------------------------------------------------------------------------
// Address range table
// Table of half-open address ranges with owner tags: add, remove, lookup.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// item in   start / busy         kind_i, start_addr_i, end_addr_i, owner_id_i,
//                                lookup_address_i
// result    done_o strobe        success_o, found_id_o
//
// Remove scans every entry; lookup scans entries in order and ends early on
// a hit. Add steps from the free-slot hint over occupied slots to a free one.
// Scans read the bound store by its single read port, one entry per cycle.
// Reset clears the per-slot occupied flags at once; no clearing pass.
// busy stays high until the result cycle; the result cannot be stalled.
// ----------------------------------------------------------------------------
module address_range_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [art_pkg::KindW-1:0] kind_i,
  input  art_pkg::addr_t          start_addr_i,
  input  art_pkg::addr_t          end_addr_i,
  input  art_pkg::addr_t          owner_id_i,
  input  art_pkg::addr_t          lookup_address_i,
  output logic                    done_o,
  output logic                    success_o,
  output art_pkg::addr_t          found_id_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  art_pkg::state_e state_q, state_d;
  art_pkg::kind_e  kind_q, kind_d;
  art_pkg::addr_t  sa_q, sa_d, ea_q, ea_d, tag_q, tag_d, la_q, la_d;
  logic [CntW-1:0] hint_q, hint_d, idx_q, idx_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pidx_q, pidx_d;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic            done_q, done_d, success_q, success_d;
  art_pkg::addr_t  found_q, found_d;

  art_pkg::addr_t  start_mem [CAPACITY];
  art_pkg::addr_t  end_mem   [CAPACITY];
  art_pkg::addr_t  owner_mem [CAPACITY];
  art_pkg::addr_t  rd_start_q, rd_end_q, rd_owner_q;
  logic            wr_en;
  logic [IdxW-1:0] aidx;

  logic            accept;
  logic            add_at_end, add_free, add_end;
  logic            is_lookup, issue;
  art_pkg::addr_t  cmp_x, cmp_lo, cmp_hi;
  logic            in_rng, own_eq, scan_hit, scan_last, scan_end;

  assign busy   = (state_q != art_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign aidx   = idx_q[IdxW-1:0];

  // add scan
  assign add_at_end = (idx_q >= CntW'(CAPACITY));
  assign add_free   = !add_at_end && !valid_q[aidx];
  assign add_end    = (tag_q == '0) || add_at_end || add_free;

  // shared range compare: lookup tests the address against stored bounds,
  // remove by span tests the stored start against the given span
  assign is_lookup = (kind_q == art_pkg::KIND_LOOKUP);
  assign cmp_x     = is_lookup ? la_q : rd_start_q;
  assign cmp_lo    = is_lookup ? rd_start_q : sa_q;
  assign cmp_hi    = is_lookup ? rd_end_q : ea_q;
  assign in_rng    = (cmp_x >= cmp_lo) && (cmp_x < cmp_hi);
  assign own_eq    = (rd_owner_q == tag_q);

  assign issue     = (idx_q < CntW'(CAPACITY));
  assign scan_hit  = pend_q && valid_q[pidx_q] &&
                     ((is_lookup || (sa_q != '0)) ? in_rng : own_eq);
  assign scan_last = pend_q && (pidx_q == IdxW'(CAPACITY - 1));
  assign scan_end  = scan_last || (is_lookup && scan_hit);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      art_pkg::ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            art_pkg::KIND_ADD:    state_d = art_pkg::ST_ADD;
            art_pkg::KIND_REMOVE: state_d = art_pkg::ST_SCAN;
            art_pkg::KIND_LOOKUP: state_d = art_pkg::ST_SCAN;
            default:              state_d = art_pkg::ST_DROP;
          endcase
        end
      end
      art_pkg::ST_ADD: begin
        if (add_end) state_d = art_pkg::ST_IDLE;
      end
      art_pkg::ST_SCAN: begin
        if (scan_end) state_d = art_pkg::ST_IDLE;
      end
      art_pkg::ST_DROP: state_d = art_pkg::ST_IDLE;
      default:          state_d = art_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_d    = kind_q;
    sa_d      = sa_q;
    ea_d      = ea_q;
    tag_d     = tag_q;
    la_d      = la_q;
    hint_d    = hint_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    valid_d   = valid_q;
    done_d    = 1'b0;
    success_d = success_q;
    found_d   = found_q;
    wr_en     = 1'b0;
    case (state_q)
      art_pkg::ST_IDLE: begin
        if (accept) begin
          kind_d = art_pkg::kind_e'(kind_i);
          sa_d   = start_addr_i;
          ea_d   = end_addr_i;
          tag_d  = owner_id_i;
          la_d   = lookup_address_i;
          idx_d  = (kind_i == art_pkg::KIND_ADD) ? hint_q : '0;
        end
      end
      art_pkg::ST_ADD: begin
        if (tag_q == '0) begin
          done_d    = 1'b1;
          success_d = 1'b0;
          found_d   = '0;
        end else if (add_at_end) begin
          done_d    = 1'b1;
          success_d = 1'b0;
          found_d   = '0;
          hint_d    = CntW'(CAPACITY);
        end else if (add_free) begin
          wr_en         = 1'b1;
          valid_d[aidx] = 1'b1;
          hint_d        = idx_q + CntW'(1);
          done_d        = 1'b1;
          success_d     = 1'b1;
          found_d       = '0;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      art_pkg::ST_SCAN: begin
        if (issue) begin
          idx_d = idx_q + CntW'(1);
        end
        pend_d = issue && !scan_end;
        pidx_d = aidx;
        if (scan_hit && !is_lookup) begin
          valid_d[pidx_q] = 1'b0;
        end
        if (scan_end) begin
          done_d    = 1'b1;
          success_d = is_lookup ? scan_hit : 1'b1;
          found_d   = (is_lookup && scan_hit) ? rd_owner_q : '0;
          if (!is_lookup) hint_d = '0;
        end
      end
      art_pkg::ST_DROP: begin
        done_d    = 1'b1;
        success_d = 1'b0;
        found_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= art_pkg::ST_IDLE;
      hint_q  <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    sa_q      <= sa_d;
    ea_q      <= ea_d;
    tag_q     <= tag_d;
    la_q      <= la_d;
    pidx_q    <= pidx_d;
    success_q <= success_d;
    found_q   <= found_d;
  end

  // bound and owner stores: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[aidx] <= sa_q;
      end_mem[aidx]   <= ea_q;
      owner_mem[aidx] <= tag_q;
    end
    rd_start_q <= start_mem[aidx];
    rd_end_q   <= end_mem[aidx];
    rd_owner_q <= owner_mem[aidx];
  end

  assign done_o     = done_q;
  assign success_o  = success_q;
  assign found_id_o = found_q;

endmodule

FILE: design/art_checker.sv
// ----------------------------------------------------------------------------
// Address range table port checker
// Watches the item and result ports over time.
// ----------------------------------------------------------------------------
`include "address_range_table_macros.svh"

module art_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input logic           success_o,
  input art_pkg::addr_t found_id_o
);

  `ART_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `ART_ASSERT_IMP(a_done_idle, done_o, !busy, "result shown while still busy")
  `ART_ASSERT_IMP(a_fail_zero, done_o && !success_o, found_id_o == '0, "failed item with tag")
  `ART_ASSERT_IMP(a_fall_done, $fell(busy), done_o, "busy dropped without a result")

endmodule

bind address_range_table art_checker u_art_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .success_o  (success_o),
  .found_id_o (found_id_o)
);
